// ===== src/fpd_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// framed packet decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

  // Payload buffer geometry
  localparam int MaxPayload = 256;
  localparam int AddrW      = $clog2(MaxPayload);
  localparam int PosW       = $clog2(MaxPayload + 1);
  localparam int LenW       = 9;

  // CRC constants
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVersion    = 2'd2;

  // Result kinds
  localparam logic KindFrame = 1'b0;
  localparam logic KindRead  = 1'b1;

  // Input mode codes
  localparam logic ModePush = 1'b0;
  localparam logic ModeRead = 1'b1;

  // Payload buffer write port
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // Good-frame report from the parser
  typedef struct packed {
    logic            valid;
    logic [7:0]      ftype;
    logic [LenW-1:0] len;
  } frame_rpt_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/fpd_payload_ram.sv =====
// Payload byte buffer: one write port, one read port, registered read data.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpd_payload_ram
  import fpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire buf_wr_t          wr_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]            rd_data_o
);

  logic [7:0] mem_q [MaxPayload];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/fpd_parser.sv =====
// Header/length/CRC parser for the framed packet decoder, holding the sync and
// version registers. Drives the payload buffer write port. Depends on fpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpd_parser
  import fpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               push_i,
  input  wire logic [7:0]         byte_i,
  output buf_wr_t                 wr_o,
  output frame_rpt_t              frame_o
);

  typedef enum logic [8:0] {
    PhSync0 = 9'b000000001,
    PhSync1 = 9'b000000010,
    PhVer   = 9'b000000100,
    PhType  = 9'b000001000,
    PhLen0  = 9'b000010000,
    PhLen1  = 9'b000100000,
    PhData  = 9'b001000000,
    PhCrc0  = 9'b010000000,
    PhCrc1  = 9'b100000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      rx_lo_q, rx_lo_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [LenW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sync_first_q, sync_second_q, version_q;
  logic [15:0]     crc_upd;
  logic [15:0]     len_full;
  logic [PosW-1:0] pos_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'd90;
      sync_second_q <= 8'd190;
      version_q     <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSyncFirst:  sync_first_q  <= cfg_data_i;
        CfgSyncSecond: sync_second_q <= cfg_data_i;
        CfgVersion:    version_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign crc_upd  = crc16_byte((phase_q == PhVer) ? CrcInit : crc_q, byte_i);
  assign len_full = {byte_i, len_lo_q};
  assign pos_inc  = pos_q + PosW'(1);

  // next-state and datapath
  always_comb begin
    phase_d       = phase_q;
    crc_d         = crc_q;
    rx_lo_d       = rx_lo_q;
    type_d        = type_q;
    len_lo_d      = len_lo_q;
    len_d         = len_q;
    pos_d         = pos_q;
    wr_o.we       = 1'b0;
    wr_o.addr     = pos_q[AddrW-1:0];
    wr_o.data     = byte_i;
    frame_o.valid = 1'b0;
    frame_o.ftype = type_q;
    frame_o.len   = len_q;
    if (push_i) begin
      unique case (phase_q)
        PhSync0: begin
          if (byte_i == sync_first_q) phase_d = PhSync1;
        end
        PhSync1: begin
          priority if (byte_i == sync_first_q) phase_d = PhSync1;
          else if (byte_i == sync_second_q) phase_d = PhVer;
          else phase_d = PhSync0;
        end
        PhVer: begin
          crc_d   = crc_upd;
          phase_d = (byte_i == version_q) ? PhType : PhSync0;
        end
        PhType: begin
          crc_d   = crc_upd;
          type_d  = byte_i;
          phase_d = PhLen0;
        end
        PhLen0: begin
          crc_d    = crc_upd;
          len_lo_d = byte_i;
          phase_d  = PhLen1;
        end
        PhLen1: begin
          crc_d = crc_upd;
          if (len_full > 16'(MaxPayload)) begin
            phase_d = PhSync0;
          end else begin
            len_d   = len_full[LenW-1:0];
            pos_d   = '0;
            phase_d = (len_full == 16'd0) ? PhCrc0 : PhData;
          end
        end
        PhData: begin
          crc_d   = crc_upd;
          wr_o.we = (pos_q < PosW'(MaxPayload));
          pos_d   = pos_inc;
          if (LenW'(pos_inc) >= len_q) phase_d = PhCrc0;
        end
        PhCrc0: begin
          rx_lo_d = byte_i;
          phase_d = PhCrc1;
        end
        PhCrc1: begin
          phase_d       = PhSync0;
          frame_o.valid = ({byte_i, rx_lo_q} == crc_q);
        end
        default: phase_d = PhSync0;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSync0;
      crc_q    <= CrcInit;
      rx_lo_q  <= '0;
      type_q   <= '0;
      len_lo_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      rx_lo_q  <= rx_lo_d;
      type_q   <= type_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
    end
  end

`ifndef SYNTHESIS
  // buffer writes only happen while payload bytes arrive
  a_wr_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (phase_q == PhData) && push_i)
    else $error("payload write outside data phase");

  // a good frame is reported only on the last CRC byte
  a_frame_on_crc1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid |=> (phase_q == PhSync0))
    else $error("frame report did not return to hunt");

  // position never runs past the held length during payload reception
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (LenW'(pos_q) < len_q))
    else $error("payload position beyond length");
`endif

endmodule

`default_nettype wire

// ===== src/framed_packet_decoder_crc16.sv =====
// Framed packet decoder with CRC-16/CCITT-FALSE check: top level.
// Depends on fpd_pkg, fpd_parser and fpd_payload_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per handshake:
//   mode_i = push takes data_byte_i into the frame parser, mode_i = read
//   returns the buffered payload byte at read_index_i.
//   Output channel (out_valid_o/out_ready_i) carries a good-frame report
//   (result_kind_o = 0, frame_type_o, payload_length_o) after the last CRC
//   byte of a frame whose CRC matches, or read data (result_kind_o = 1).
//   A result is registered and appears in the cycle after its word. Throughput:
//   one word per cycle while results are taken; the parser updates the CRC a
//   byte at a time and the payload buffer takes one write or one read per cycle.
//   The output register holds a result until taken; in_ready_o is high
//   when that register is empty or is being emptied in the same cycle.
//   Reset sets the sync bytes to 0x5A/0xBE, the version to 1 and starts
//   hunting for the first sync byte; the payload buffer is not cleared,
//   so only indexes written by a received frame may be read. The user must write
//   configuration (cfg_we_i) only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_decoder_crc16
  import fpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic [7:0]         read_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    result_kind_o,
  output logic [7:0]              frame_type_o,
  output logic [LenW-1:0]         payload_length_o,
  output logic [7:0]              read_data_o
);

  logic            accept;
  logic            push;
  logic            rd_en;
  buf_wr_t         buf_wr;
  frame_rpt_t      frame;
  logic [7:0]      rd_data;
  logic            out_valid_q, out_valid_d;
  logic            kind_q;
  logic [7:0]      type_q;
  logic [LenW-1:0] len_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && (mode_i == ModePush);
  assign rd_en      = accept && (mode_i == ModeRead);

  fpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .byte_i      (data_byte_i),
    .wr_o        (buf_wr),
    .frame_o     (frame)
  );

  fpd_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (read_index_i[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // output register valid
  always_comb begin
    priority if (accept) out_valid_d = rd_en || frame.valid;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload; read data itself sits in the buffer's read register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= rd_en ? KindRead : KindFrame;
      type_q <= frame.ftype;
      len_q  <= frame.len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign frame_type_o     = (kind_q == KindFrame) ? type_q : 8'd0;
  assign payload_length_o = (kind_q == KindFrame) ? len_q : '0;
  assign read_data_o      = (kind_q == KindRead) ? rd_data : 8'd0;

`ifndef SYNTHESIS
  // a read word always produces a read result in the next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> out_valid_o && (result_kind_o == KindRead))
    else $error("read word gave no read result");

  // a good frame is reported as a frame result in the next cycle
  a_push_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && frame.valid) |=> out_valid_o && (result_kind_o == KindFrame))
    else $error("good frame not reported");

  // the buffer is never written and read in the same cycle
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(buf_wr.we && rd_en))
    else $error("buffer write and read collide");
`endif

endmodule

`default_nettype wire
